>>> rtl/tcp_syn_packet_builder_core_macros.svh
// Assertion macros used by the probe builder core.
`ifndef TCP_SYN_PACKET_BUILDER_CORE_MACROS_SVH
`define TCP_SYN_PACKET_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tsp_pkg.sv
// ----------------------------------------------------------------------------
// tsp_pkg
// Types and constants shared by the TCP SYN probe builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

	localparam int PKT_LEN = 40;
	localparam int POS_W   = 6;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(PKT_LEN - 1);

	// Configuration register indexes.
	localparam logic [1:0] CFG_SRC_ADDR = 2'd0;
	localparam logic [1:0] CFG_SRC_PORT = 2'd1;

	localparam logic [15:0] SRC_PORT_RST = 16'd6553;
	localparam logic [31:0] SEQ_RST      = 32'd1;

	// Fixed header bytes.
	localparam logic [7:0] VER_IHL     = 8'h45;
	localparam logic [7:0] TOTAL_LEN   = 8'(PKT_LEN);
	localparam logic [7:0] TTL_MAX     = 8'hFF;
	localparam logic [7:0] PROTO_TCP   = 8'h06;
	localparam logic [7:0] DATA_OFFSET = 8'h50;
	localparam logic [7:0] FLAG_SYN    = 8'h02;

	// Sum of the constant 16-bit words of the IPv4 header:
	// 0x4500 + 0x0028 + 0xFF06.
	localparam logic [18:0] IP_SUM_BASE  = 19'h1442E;
	// Pseudo-header protocol and length plus the offset/flags word:
	// 0x0006 + 0x0014 + 0x5002.
	localparam logic [19:0] TCP_SUM_BASE = 20'h0501C;

	typedef logic [PKT_LEN-1:0][7:0] pkt_t;

	typedef struct packed {
		logic             valid;
		logic [7:0]       data;
		logic [POS_W-1:0] pos;
		logic             last;
	} cell_t;

endpackage

`default_nettype wire

>>> rtl/tsp_cell.sv
// ----------------------------------------------------------------------------
// tsp_cell
// One byte cell of the output chain: loads in parallel or takes its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic          shift,
	input  tsp_pkg::cell_t load_cell,
	input  tsp_pkg::cell_t next_cell,
	output tsp_pkg::cell_t cur_cell
);
	import tsp_pkg::*;

	logic             valid_q;
	logic [7:0]       data_q;
	logic [POS_W-1:0] pos_q;
	logic             last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_cell.valid;
		end else if (shift) begin
			valid_q <= next_cell.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_cell.data;
			pos_q  <= load_cell.pos;
			last_q <= load_cell.last;
		end else if (shift) begin
			data_q <= next_cell.data;
			pos_q  <= next_cell.pos;
			last_q <= next_cell.last;
		end
	end

	assign cur_cell = '{valid: valid_q, data: data_q, pos: pos_q, last: last_q};

endmodule

`default_nettype wire

>>> rtl/tsp_build.sv
// ----------------------------------------------------------------------------
// tsp_build
// Checksum pipeline: captures one probe request and assembles its 40 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_build (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          take,
	input  logic [31:0]   target_address,
	input  logic [15:0]   target_port,
	input  logic [31:0]   seq,
	input  logic [31:0]   src_addr,
	input  logic [15:0]   src_port,
	output logic          busy,
	output logic          done,
	output tsp_pkg::pkt_t pkt
);
	import tsp_pkg::*;

	logic        vld_s1, vld_s2, vld_s3, rdy_q;
	logic [31:0] dst_s1, seq_s1, src_s1;
	logic [15:0] dport_s1, sport_s1;
	logic [16:0] src_sum_s2, dst_sum_s2, port_sum_s2, seq_sum_s2;
	logic [18:0] ip_raw_s3;
	logic [19:0] tcp_raw_s3;
	logic [16:0] ip_fold_s4, tcp_fold_s4;
	logic [15:0] ip_ck, tcp_ck;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			rdy_q  <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			if (vld_s3) begin
				rdy_q <= 1'b1;
			end else if (take) begin
				rdy_q <= 1'b0;
			end
		end
	end

	// Only one request is in flight, so the captured fields stay put until
	// the packet has moved into the output chain.
	always_ff @(posedge clk) begin
		if (start) begin
			dst_s1   <= target_address;
			dport_s1 <= target_port;
			seq_s1   <= seq;
			src_s1   <= src_addr;
			sport_s1 <= src_port;
		end
		if (vld_s1) begin
			src_sum_s2  <= {1'b0, src_s1[31:16]} + {1'b0, src_s1[15:0]};
			dst_sum_s2  <= {1'b0, dst_s1[31:16]} + {1'b0, dst_s1[15:0]};
			port_sum_s2 <= {1'b0, sport_s1} + {1'b0, dport_s1};
			seq_sum_s2  <= {1'b0, seq_s1[31:16]} + {1'b0, seq_s1[15:0]};
		end
		if (vld_s2) begin
			ip_raw_s3  <= 19'(src_sum_s2) + 19'(dst_sum_s2) + IP_SUM_BASE;
			tcp_raw_s3 <= 20'(src_sum_s2) + 20'(dst_sum_s2) + 20'(port_sum_s2)
				+ 20'(seq_sum_s2) + TCP_SUM_BASE;
		end
		if (vld_s3) begin
			ip_fold_s4  <= {1'b0, ip_raw_s3[15:0]} + 17'(ip_raw_s3[18:16]);
			tcp_fold_s4 <= {1'b0, tcp_raw_s3[15:0]} + 17'(tcp_raw_s3[19:16]);
		end
	end

	// After the first fold the carry is at most one, and adding it back
	// cannot carry again.
	assign ip_ck  = ~(ip_fold_s4[15:0] + 16'(ip_fold_s4[16]));
	assign tcp_ck = ~(tcp_fold_s4[15:0] + 16'(tcp_fold_s4[16]));

	always_comb begin
		pkt     = '0;
		pkt[0]  = VER_IHL;
		pkt[3]  = TOTAL_LEN;
		pkt[8]  = TTL_MAX;
		pkt[9]  = PROTO_TCP;
		pkt[10] = ip_ck[15:8];
		pkt[11] = ip_ck[7:0];
		pkt[12] = src_s1[31:24];
		pkt[13] = src_s1[23:16];
		pkt[14] = src_s1[15:8];
		pkt[15] = src_s1[7:0];
		pkt[16] = dst_s1[31:24];
		pkt[17] = dst_s1[23:16];
		pkt[18] = dst_s1[15:8];
		pkt[19] = dst_s1[7:0];
		pkt[20] = sport_s1[15:8];
		pkt[21] = sport_s1[7:0];
		pkt[22] = dport_s1[15:8];
		pkt[23] = dport_s1[7:0];
		pkt[24] = seq_s1[31:24];
		pkt[25] = seq_s1[23:16];
		pkt[26] = seq_s1[15:8];
		pkt[27] = seq_s1[7:0];
		pkt[32] = DATA_OFFSET;
		pkt[33] = FLAG_SYN;
		pkt[36] = tcp_ck[15:8];
		pkt[37] = tcp_ck[7:0];
	end

	assign busy = vld_s1 | vld_s2 | vld_s3 | rdy_q;
	assign done = rdy_q;

endmodule

`default_nettype wire

>>> rtl/tcp_syn_packet_builder_core.sv
// ----------------------------------------------------------------------------
// tcp_syn_packet_builder_core
// Builds 40-byte IPv4/TCP SYN probes, streamed one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one probe request per transaction: a destination
// address and port. The output channel carries one packet byte per
// transaction with its offset and a flag on the final byte, 40 transactions
// per probe in wire order. Both channels use valid/stall handshakes.
// A request passes a four-stage checksum pipeline and is then loaded in
// parallel into a chain of 40 byte cells, which shifts one byte out per
// taken transaction. A new request is accepted as soon as the previous one
// has entered the chain, so its checksums are ready while the earlier probe
// drains. When the receiver stalls, the chain holds and the byte on the port
// stays unchanged; once a request is waiting in the pipeline, in_stall is
// high. Reset empties the chain, sets the sequence number to one, the source
// address to zero and the source port to 6553. The user must make
// configuration writes only while the block is idle; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_syn_packet_builder_core (
	input  logic                      clk,
	input  logic                      arst_n,
	// Configuration write port.
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	// Request channel.
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [31:0]               target_address,
	input  logic [15:0]               target_port,
	// Byte channel.
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                packet_byte,
	output logic [tsp_pkg::POS_W-1:0] byte_position,
	output logic                      last_byte
);
	import tsp_pkg::*;

`include "tcp_syn_packet_builder_core_macros.svh"

	logic [31:0] src_addr_q;
	logic [15:0] src_port_q;
	logic [31:0] seq_q;

	logic  in_take, out_take;
	logic  build_busy, build_done;
	logic  chain_load;
	pkt_t  pkt;
	cell_t chain [PKT_LEN];

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign in_stall = build_busy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
			src_port_q <= SRC_PORT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SRC_ADDR: src_addr_q <= cfg_data;
				CFG_SRC_PORT: src_port_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// The sequence number advances once per accepted request and wraps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_RST;
		end else if (in_take) begin
			seq_q <= seq_q + 32'd1;
		end
	end

	tsp_build u_build (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (in_take),
		.take           (chain_load),
		.target_address (target_address),
		.target_port    (target_port),
		.seq            (seq_q),
		.src_addr       (src_addr_q),
		.src_port       (src_port_q),
		.busy           (build_busy),
		.done           (build_done),
		.pkt            (pkt)
	);

	// A finished packet enters the chain when the chain is empty or its
	// final byte leaves in this cycle. Whole packets go in and out, so a
	// valid last byte at the head means every other cell is empty.
	assign chain_load = build_done && (!chain[0].valid || (chain[0].last && out_take));

	for (genvar i = 0; i < PKT_LEN; i++) begin : g_cell
		cell_t load_c, next_c;

		assign load_c = '{valid: 1'b1, data: pkt[i], pos: POS_W'(i),
			last: (i == PKT_LEN - 1)};

		if (i == PKT_LEN - 1) begin : g_tail
			assign next_c = '0;
		end else begin : g_body
			assign next_c = chain[i+1];
		end

		tsp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (chain_load),
			.shift     (out_take),
			.load_cell (load_c),
			.next_cell (next_c),
			.cur_cell  (chain[i])
		);
	end

	// The head cell is the output register.
	assign out_valid     = chain[0].valid;
	assign packet_byte   = chain[0].data;
	assign byte_position = chain[0].pos;
	assign last_byte     = chain[0].last;

	// A taken byte that is not the last is followed by the next offset.
	`TSP_ASSERT_NEXT(a_pos_advance, clk, arst_n, out_take && !last_byte,
		out_valid && (byte_position == POS_W'($past(byte_position) + 1'b1)),
		"byte offset did not advance within a packet")

	// The flag marks exactly the final offset.
	`TSP_ASSERT_NOW(a_last_flag, clk, arst_n, out_valid,
		last_byte == (byte_position == LAST_POS),
		"last byte flag disagrees with offset")

	// With nothing built, the output goes quiet after the final byte.
	`TSP_ASSERT_NEXT(a_drain, clk, arst_n, out_take && last_byte && !build_done,
		!out_valid, "output valid after final byte with no packet ready")

	// An accepted request holds off the next one until it is loaded.
	`TSP_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_take, in_stall,
		"request accepted while another one is in flight")

endmodule

`default_nettype wire

>>> bench/tsp_probe_checker.sv
// ----------------------------------------------------------------------------
// tsp_probe_checker
// Predicts the 40 bytes of each SYN probe and compares them with the byte
// channel. It follows the configuration port and counts the failures.
// ----------------------------------------------------------------------------

module tsp_probe_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [31:0]               target_address,
	input  logic [15:0]               target_port,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [7:0]                packet_byte,
	input  logic [tsp_pkg::POS_W-1:0] byte_position,
	input  logic                      last_byte,
	output int                        failures,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsp_pkg::*;

	localparam logic [31:0] TCP_HDR_LEN = 32'd20;

	typedef struct packed {
		logic [7:0]       data;
		logic [POS_W-1:0] pos;
		logic             last;
	} wire_byte_t;

	logic [31:0] src_addr_reg;
	logic [15:0] src_port_reg;
	logic [31:0] seq_num;
	wire_byte_t  expected_bytes[$];

	// End-around carry of a 16-bit ones'-complement sum.
	function automatic logic [31:0] fold_carries(input logic [31:0] acc);
		while (acc[31:16] != 16'd0)
			acc = acc[31:16] + acc[15:0];
		return acc;
	endfunction

	function automatic pkt_t build_probe(input logic [31:0] src, input logic [15:0] sport,
			input logic [31:0] dst, input logic [15:0] dport, input logic [31:0] seq);
		pkt_t        p;
		logic [31:0] acc;
		int          k;
		p = '0;
		p[0] = VER_IHL;
		p[3] = TOTAL_LEN;
		p[8] = TTL_MAX;
		p[9] = PROTO_TCP;
		{p[12], p[13], p[14], p[15]} = src;
		{p[16], p[17], p[18], p[19]} = dst;
		{p[20], p[21]} = sport;
		{p[22], p[23]} = dport;
		{p[24], p[25], p[26], p[27]} = seq;
		p[32] = DATA_OFFSET;
		p[33] = FLAG_SYN;

		acc = '0;
		for (k = 0; k < 20; k += 2)
			acc += {16'd0, p[k], p[k + 1]};
		acc = fold_carries(acc);
		{p[10], p[11]} = ~acc[15:0];

		// The TCP sum starts from the pseudo-header.
		acc = {16'd0, src[31:16]} + {16'd0, src[15:0]} + {16'd0, dst[31:16]}
			+ {16'd0, dst[15:0]} + {24'd0, PROTO_TCP} + TCP_HDR_LEN;
		for (k = 20; k < PKT_LEN; k += 2)
			acc += {16'd0, p[k], p[k + 1]};
		acc = fold_carries(acc);
		{p[36], p[37]} = ~acc[15:0];
		return p;
	endfunction

	initial begin
		failures = 0;
		pending = 0;
		src_addr_reg = '0;
		src_port_reg = SRC_PORT_RST;
		seq_num = SEQ_RST;
	end

	always @(posedge clk or negedge arst_n) begin
		wire_byte_t want;
		pkt_t       probe;
		if (!arst_n) begin
			src_addr_reg = '0;
			src_port_reg = SRC_PORT_RST;
			seq_num = SEQ_RST;
			expected_bytes.delete();
		end else begin
			// Writes to an unused index leave both registers alone.
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_SRC_ADDR: src_addr_reg = cfg_data;
					CFG_SRC_PORT: src_port_reg = cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					failures++;
					$error("packet_byte %h at byte_position %0d with no probe outstanding",
						packet_byte, byte_position);
				end else begin
					want = expected_bytes.pop_front();
					if (packet_byte !== want.data) begin
						failures++;
						$error("packet_byte: expected %h, got %h", want.data, packet_byte);
					end
					if (byte_position !== want.pos) begin
						failures++;
						$error("byte_position: expected %0d, got %0d", want.pos, byte_position);
					end
					if (last_byte !== want.last) begin
						failures++;
						$error("last_byte: expected %b, got %b", want.last, last_byte);
					end
				end
			end

			if (in_valid && !in_stall) begin
				probe = build_probe(src_addr_reg, src_port_reg, target_address, target_port,
					seq_num);
				for (int i = 0; i < PKT_LEN; i++)
					expected_bytes.push_back('{probe[i], POS_W'(i), i == PKT_LEN - 1});
				seq_num = seq_num + 32'd1;
			end
		end
		pending = expected_bytes.size();
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives probe requests and configuration writes into the SYN probe builder
// and stalls the byte channel at random; a checker beside the block predicts
// and compares every byte, and this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tsp_pkg::*;

	// Indexes that map to no register; writes to them must be ignored.
	localparam logic [1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [1:0] CFG_SPARE_3 = 2'd3;

	// Number of random phases and requests in each of them.
	localparam int RANDOM_PHASES    = 6;
	localparam int PROBES_PER_PHASE = 56;
	// The receiver refuses every byte for a long stretch once, well into
	// the random part, so the byte chain and the checksum pipeline fill up.
	localparam int HOLD_AFTER_BYTES = 2000;
	localparam int HOLD_CYCLES      = 300;
	// Cycles without any transaction before the run is declared hung.
	localparam int WATCHDOG_LIMIT   = 2000;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [1:0]       cfg_index;
	logic [31:0]      cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [31:0]      target_address;
	logic [15:0]      target_port;
	logic             out_valid;
	logic             out_stall;
	logic [7:0]       packet_byte;
	logic [POS_W-1:0] byte_position;
	logic             last_byte;

	int failures;
	int pending;
	int quiet_cycles;
	bit tx_calm;
	bit rx_calm;

	tcp_syn_packet_builder_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.target_address(target_address),
		.target_port   (target_port),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.packet_byte   (packet_byte),
		.byte_position (byte_position),
		.last_byte     (last_byte)
	);

	tsp_probe_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.target_address(target_address),
		.target_port   (target_port),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.packet_byte   (packet_byte),
		.byte_position (byte_position),
		.last_byte     (last_byte),
		.failures      (failures),
		.pending       (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offers one probe request and returns at the falling edge after the
	// transaction. The gap before it is drawn per request; in calm
	// stretches the requests follow back to back.
	task automatic send_probe(input logic [31:0] addr, input logic [15:0] port);
		int gap;
		if ($urandom_range(0, 31) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		target_address <= addr;
		target_port <= port;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Drives one register write for a single cycle. Back-to-back writes keep
	// the enable high; the caller lowers it after the last one.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
	endtask

	// Stops offering requests and waits until every predicted byte has been
	// taken, then lets the pipeline settle before anything else happens.
	task automatic drain(input int tail);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// Address picks lean on the extremes now and then.
	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_port();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_SRC_ADDR;
		cfg_data = '0;
		in_valid = 1'b0;
		target_address = '0;
		target_port = '0;
		tx_calm = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration. The first probe after reset has sequence
		// number one, and with the default source this destination makes
		// both the IPv4 and the TCP checksum come out as zero.
		send_probe(32'h0000_BBD0, 16'hDA78);
		send_probe(32'h0000_0000, 16'h0000);
		send_probe(32'hFFFF_FFFF, 16'hFFFF);
		send_probe(32'hAAAA_AAAA, 16'h5555);
		send_probe(32'h5555_5555, 16'hAAAA);
		send_probe(32'h0000_0000, 16'hFFFF);
		send_probe(32'hFFFF_FFFF, 16'h0000);
		send_probe(32'h8000_0001, 16'h8001);
		send_probe(32'hC0A8_0101, 16'd80);
		send_probe(32'h0000_BBD6, 16'h0000);

		// Source address and port at their maximum. The port write carries
		// ones in the upper data bits, which the register must drop.
		drain(8);
		write_reg(CFG_SRC_ADDR, 32'hFFFF_FFFF);
		write_reg(CFG_SRC_PORT, 32'hFFFF_FFFF);
		cfg_wr_en <= 1'b0;
		send_probe(32'h0000_0000, 16'h0000);
		send_probe(32'hFFFF_FFFF, 16'hFFFF);
		send_probe(32'h1234_5678, 16'h9ABC);
		send_probe(32'hFFFF_0000, 16'h00FF);

		// Writes to the unused indexes must not disturb anything; then both
		// registers go to zero.
		drain(8);
		write_reg(CFG_SPARE_2, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_3, 32'hA5A5_5A5A);
		cfg_wr_en <= 1'b0;
		send_probe(32'h0A00_0001, 16'd443);
		send_probe(32'hFFFF_FFFF, 16'h0001);
		drain(8);
		write_reg(CFG_SRC_ADDR, 32'h0000_0000);
		write_reg(CFG_SRC_PORT, 32'hFFFF_0000);
		cfg_wr_en <= 1'b0;
		send_probe(32'h0000_0000, 16'h0000);
		send_probe(32'hFFFF_FFFF, 16'hFFFF);
		send_probe(32'h7FFF_FFFF, 16'h7FFF);

		// Random phases: a fresh configuration each time, sometimes with a
		// stray write to an unused index, then a run of random requests.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain(8);
			if ($urandom_range(0, 2) == 0)
				write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
			write_reg(CFG_SRC_ADDR, pick_address());
			write_reg(CFG_SRC_PORT, $urandom);
			cfg_wr_en <= 1'b0;
			for (int n = 0; n < PROBES_PER_PHASE; n++)
				send_probe(pick_address(), pick_port());
		end

		drain(20);
		if (failures == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Byte receiver. It stalls a random number of cycles before each byte,
	// with calm stretches where it takes every byte at once, and one long
	// hold-off partway through the run.
	initial begin : receiver
		int gap;
		int bytes_taken;
		out_stall = 1'b0;
		rx_calm = 1'b0;
		bytes_taken = 0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 63) == 0)
				rx_calm = !rx_calm;
			gap = rx_calm ? 0 : $urandom_range(0, 10);
			if (bytes_taken == HOLD_AFTER_BYTES)
				gap = HOLD_CYCLES;
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
			bytes_taken++;
		end
	end

	// A run that stops moving ends as a failure. Configuration cycles count
	// as activity, so the quiet settling phases stay far below the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
